>>> hw/rtl/npc_pkg.sv
// shared types, constants and helper functions for the nearest palette color block
`timescale 1ns / 1ps

package npc_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned DIST_W      = 18;
  localparam int unsigned MID_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned CREDIT_W    = 4;

  // 255 * 256, split into the two halves used by the divider stages
  localparam logic [SCALE_W-1:0] FULL_SCALE = 16'hFF00;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic  gray;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t top;
  } item_t;

  typedef logic [REG_COUNT-1:0][COLOR_W-1:0] palette_t;

  localparam palette_t PAL_RESET = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h0000FF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h000000
  };

  typedef struct packed {
    chan_t quot;
    chan_t rem;
  } div_part_t;

  // eight restoring division steps
  function automatic div_part_t div_steps(chan_t num, chan_t rem_in, chan_t den);
    div_part_t  res;
    logic [8:0] r;
    r = {1'b0, rem_in};
    res.quot = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[7:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        res.quot[i] = 1'b1;
      end
    end
    res.rem = r[7:0];
    return res;
  endfunction

  function automatic logic [SCALE_W-1:0] abs_diff(logic [SCALE_W-1:0] a,
                                                  logic [SCALE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> hw/rtl/npc_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module npc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/npc_front.sv
// front end: gray detection and largest component of an incoming pixel
`timescale 1ns / 1ps

module npc_front (
  input  npc_pkg::chan_t red_i,
  input  npc_pkg::chan_t green_i,
  input  npc_pkg::chan_t blue_i,
  output npc_pkg::item_t item_o
);

  npc_pkg::chan_t top_rg;

  assign top_rg = (green_i > red_i) ? green_i : red_i;

  always_comb begin
    item_o.gray  = (red_i == green_i) && (red_i == blue_i);
    item_o.red   = red_i;
    item_o.green = green_i;
    item_o.blue  = blue_i;
    item_o.top   = (blue_i > top_rg) ? blue_i : top_rg;
  end

endmodule

>>> hw/rtl/npc_back.sv
// back end: scale division, normalization, palette distances and best match
`timescale 1ns / 1ps

module npc_back #(
  parameter int unsigned NUM_COLORS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  npc_pkg::item_t                 item_i,
  input  logic                           item_valid_i,
  output logic                           item_pop_o,
  input  npc_pkg::palette_t              palette_i,
  input  logic                           res_pop_i,
  output logic                           res_valid_o,
  output logic [npc_pkg::IDX_W-1:0]      res_index_o
);

  localparam int unsigned SW = npc_pkg::SCALE_W;
  localparam int unsigned DW = npc_pkg::DIST_W;
  localparam int unsigned CW = npc_pkg::CREDIT_W;

  // credits cover the pipeline plus the result queue
  logic [CW-1:0] credit_q, credit_d;

  logic                 s1_valid_q;
  npc_pkg::item_t       s1_item_q;
  npc_pkg::div_part_t   s1_div_q;
  npc_pkg::div_part_t   div_hi, div_lo;

  logic                 s2_valid_q;
  npc_pkg::item_t       s2_item_q;
  logic [SW-1:0]        s2_scale_q;

  logic                 s3_valid_q, s3_gray_q, s3_hi_q;
  logic [SW-1:0]        s3_prod_q [3];
  logic [SW+7:0]        prod_r, prod_g, prod_b;

  logic                 s4_valid_q, s4_gray_q, s4_hi_q;
  logic [DW-1:0]        s4_dist_q [NUM_COLORS];
  logic [DW-1:0]        pal_dist [NUM_COLORS];

  logic                 s5_valid_q;
  logic [npc_pkg::IDX_W-1:0] s5_index_q, best_idx;
  logic [DW-1:0]        best_dist;

  assign item_pop_o = item_valid_i &&
                      ((credit_q < CW'(npc_pkg::OUT_DEPTH)) || res_pop_i);
  assign credit_d   = credit_q + CW'(item_pop_o) - CW'(res_pop_i);

  assign div_hi = npc_pkg::div_steps(npc_pkg::FULL_SCALE[15:8], '0, item_i.top);
  assign div_lo = npc_pkg::div_steps(npc_pkg::FULL_SCALE[7:0], s1_div_q.rem,
                                     s1_item_q.top);

  assign prod_r = s2_item_q.red   * s2_scale_q;
  assign prod_g = s2_item_q.green * s2_scale_q;
  assign prod_b = s2_item_q.blue  * s2_scale_q;

  always_comb begin
    for (int k = 0; k < NUM_COLORS; k++) begin
      pal_dist[k] = DW'(npc_pkg::abs_diff({palette_i[k][23:16], 8'h00}, s3_prod_q[0]))
                  + DW'(npc_pkg::abs_diff({palette_i[k][15:8], 8'h00}, s3_prod_q[1]))
                  + DW'(npc_pkg::abs_diff({palette_i[k][7:0], 8'h00}, s3_prod_q[2]));
    end
  end

  always_comb begin
    best_dist = s4_dist_q[0];
    best_idx  = '0;
    for (int k = 1; k < NUM_COLORS; k++) begin
      if (s4_dist_q[k] < best_dist) begin
        best_dist = s4_dist_q[k];
        best_idx  = npc_pkg::IDX_W'(k);
      end
    end
    if (s4_gray_q) begin
      best_idx = s4_hi_q ? npc_pkg::IDX_W'(NUM_COLORS - 1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      credit_q   <= credit_d;
      s1_valid_q <= item_pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q    <= item_i;
    s1_div_q     <= div_hi;
    s2_item_q    <= s1_item_q;
    s2_scale_q   <= {s1_div_q.quot, div_lo.quot};
    s3_gray_q    <= s2_item_q.gray;
    s3_hi_q      <= s2_item_q.red[7];
    s3_prod_q[0] <= prod_r[SW-1:0];
    s3_prod_q[1] <= prod_g[SW-1:0];
    s3_prod_q[2] <= prod_b[SW-1:0];
    s4_gray_q    <= s3_gray_q;
    s4_hi_q      <= s3_hi_q;
    for (int k = 0; k < NUM_COLORS; k++) begin
      s4_dist_q[k] <= pal_dist[k];
    end
    s5_index_q   <= best_idx;
  end

  assign res_valid_o = s5_valid_q;
  assign res_index_o = s5_index_q;

endmodule

>>> hw/rtl/nearest_palette_color.sv
// top level of the nearest palette color matcher
`timescale 1ns / 1ps

// Maps each RGB pixel to the index of the closest of NUM_COLORS palette
// entries (sum of absolute differences after brightness normalization;
// lowest index wins ties; pure gray pixels give 0 below 128, else the last
// index). Sustained rate is one pixel per clock while results are popped as
// fast. A pixel passes through two queues and a five-stage back pipeline
// (two radix-256 halves of the scale division, the multiply, the distances,
// the minimum search). The result queue holds eight entries and the back
// pipeline only takes a pixel when a queue slot is reserved for it. Palette
// registers are written through the configuration channel, which is always
// ready, and should only be written while no pixel is in flight.

module nearest_palette_color #(
  parameter int unsigned NUM_COLORS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [npc_pkg::CH_W-1:0]          red_i,
  input  logic [npc_pkg::CH_W-1:0]          green_i,
  input  logic [npc_pkg::CH_W-1:0]          blue_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [npc_pkg::IDX_W-1:0]         color_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [npc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [npc_pkg::COLOR_W-1:0]       cfg_data_i
);

  localparam int unsigned ITEM_W = $bits(npc_pkg::item_t);

  npc_pkg::palette_t   palette_q;
  npc_pkg::item_t      front_item, back_item;
  logic [ITEM_W-1:0]   mid_data;
  logic                mid_empty, mid_pop;
  logic                res_valid;
  logic [npc_pkg::IDX_W-1:0] res_index;
  logic                out_pop;

  assign cfg_ready_o = 1'b1;
  assign out_pop     = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= npc_pkg::PAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < npc_pkg::CFG_INDEX_W'(npc_pkg::REG_COUNT))) begin
      palette_q[cfg_index_i[npc_pkg::REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  npc_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .item_o  (front_item)
  );

  npc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (npc_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign back_item = mid_data;

  npc_back #(
    .NUM_COLORS (NUM_COLORS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (~mid_empty),
    .item_pop_o   (mid_pop),
    .palette_i    (palette_q),
    .res_pop_i    (out_pop),
    .res_valid_o  (res_valid),
    .res_index_o  (res_index)
  );

  npc_fifo #(
    .WIDTH (npc_pkg::IDX_W),
    .DEPTH (npc_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_index),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (color_index_o),
    .empty_o (empty)
  );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the nearest palette color matcher
`timescale 1ns / 1ps

module tb_top;
  import npc_pkg::*;

  localparam int unsigned NUM_COLORS    = 8;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned GRAY_SPLIT    = 128;
  localparam int unsigned FULL_SPAN     = 255 * 256;
  localparam int unsigned PAL_WEIGHT    = 256;
  localparam int unsigned DIRECTED_ROWS = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_LAST    = 8'd255;

  localparam logic [COLOR_W-1:0] RESET_PALETTE [REG_COUNT] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  typedef enum int unsigned {
    PAL_RANDOM, PAL_ALL_BLACK, PAL_DUPLICATED, PAL_ALL_WHITE, PAL_RANDOM_2, PAL_RESTORE
  } palette_kind_e;

  typedef struct packed {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic             typed;
    logic [IDX_W-1:0] index;
  } pixel_row_t;

  localparam pixel_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 3'd0},
    '{8'd127, 8'd127, 8'd127, 1'b1, 3'd0},
    '{8'd128, 8'd128, 8'd128, 1'b1, 3'd7},
    '{8'd255, 8'd255, 8'd255, 1'b1, 3'd7},
    '{8'd255, 8'd0,   8'd0,   1'b1, 3'd1},
    '{8'd0,   8'd255, 8'd0,   1'b1, 3'd2},
    '{8'd255, 8'd255, 8'd0,   1'b1, 3'd3},
    '{8'd0,   8'd0,   8'd255, 1'b1, 3'd4},
    '{8'd255, 8'd0,   8'd255, 1'b1, 3'd5},
    '{8'd0,   8'd255, 8'd255, 1'b1, 3'd6},
    '{8'd1,   8'd0,   8'd0,   1'b1, 3'd1},
    '{8'd0,   8'd0,   8'd1,   1'b1, 3'd4},
    '{8'd254, 8'd255, 8'd255, 1'b0, 3'd0},
    '{8'd255, 8'd255, 8'd254, 1'b0, 3'd0},
    '{8'd2,   8'd1,   8'd0,   1'b0, 3'd0},
    '{8'd128, 8'd127, 8'd127, 1'b0, 3'd0},
    '{8'd127, 8'd128, 8'd128, 1'b0, 3'd0},
    '{8'd170, 8'd85,  8'd255, 1'b0, 3'd0},
    '{8'd85,  8'd170, 8'd0,   1'b0, 3'd0},
    '{8'd3,   8'd255, 8'd128, 1'b0, 3'd0}
  };

  typedef struct {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [IDX_W-1:0] index;
  } pending_pixel_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   push        = 1'b0;
  logic                   pop         = 1'b0;
  chan_t                  red_i       = '0;
  chan_t                  green_i     = '0;
  chan_t                  blue_i      = '0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [COLOR_W-1:0]     cfg_data_i  = '0;
  logic                   use_typed   = 1'b0;
  logic [IDX_W-1:0]       typed_index = '0;
  wire                    full;
  wire                    empty;
  wire                    cfg_ready_o;
  wire  [IDX_W-1:0]       color_index_o;

  logic [COLOR_W-1:0] palette_copy [REG_COUNT];
  pending_pixel_t     expected_index_q [$];
  int unsigned        send_idle_pct   = 0;
  int unsigned        recv_idle_pct   = 0;
  int unsigned        mismatches      = 0;
  int unsigned        results_checked = 0;
  int unsigned        pixels_sent     = 0;
  int unsigned        cycle_count     = 0;

  nearest_palette_color #(
    .NUM_COLORS(NUM_COLORS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .empty        (empty),
    .pop          (pop),
    .color_index_o(color_index_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int unsigned span_gap(int unsigned a, int unsigned b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [IDX_W-1:0] nearest_index(chan_t r, chan_t g, chan_t b);
    int unsigned      top;
    int unsigned      scale;
    int unsigned      gap_sum;
    int unsigned      best_dist;
    logic [IDX_W-1:0] best;
    if (r == g && g == b) begin
      return (r < GRAY_SPLIT) ? '0 : IDX_W'(NUM_COLORS - 1);
    end
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    scale     = FULL_SPAN / top;
    best_dist = 32'hFFFF_FFFF;
    best      = '0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      gap_sum = span_gap(palette_copy[k][23:16] * PAL_WEIGHT, r * scale)
              + span_gap(palette_copy[k][15:8] * PAL_WEIGHT, g * scale)
              + span_gap(palette_copy[k][7:0] * PAL_WEIGHT, b * scale);
      if (gap_sum < best_dist) begin
        best_dist = gap_sum;
        best      = IDX_W'(k);
      end
    end
    return best;
  endfunction

  // prediction at the accepting edge, comparison at the popping edge
  always @(posedge clk_i) begin : scoreboard
    pending_pixel_t beat;
    if (rst_ni) begin
      if (push && !full) begin
        beat.red   = red_i;
        beat.green = green_i;
        beat.blue  = blue_i;
        beat.index = use_typed ? typed_index : nearest_index(red_i, green_i, blue_i);
        expected_index_q.push_back(beat);
      end
      if (pop && !empty) begin
        if (expected_index_q.size() == 0) begin
          mismatches++;
          $display("%0t: color index %0d popped with no pixel outstanding, expected none",
                   $time, color_index_o);
        end else begin
          beat = expected_index_q.pop_front();
          results_checked++;
          if (color_index_o !== beat.index) begin
            mismatches++;
            $display("%0t: pixel %0d/%0d/%0d color index expected %0d, actual %0d",
                     $time, beat.red, beat.green, beat.blue, beat.index, color_index_o);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // all tasks below start and end just after a falling edge
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic typed, input logic [IDX_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    red_i       <= r;
    green_i     <= g;
    blue_i      <= b;
    use_typed   <= typed;
    typed_index <= index;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain(input int unsigned extra);
    push <= 1'b0;
    @(negedge clk_i);
    while (expected_index_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [COLOR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index < REG_COUNT) palette_copy[index[REG_IDX_W-1:0]] = data;
    @(negedge clk_i);
  endtask

  task automatic load_palette(input palette_kind_e kind);
    logic [COLOR_W-1:0] word;
    for (int k = 0; k < REG_COUNT; k++) begin
      case (kind)
        PAL_ALL_BLACK: word = '0;
        PAL_ALL_WHITE: word = '1;
        PAL_RESTORE:   word = RESET_PALETTE[k];
        PAL_DUPLICATED: begin
          word = (k % 2 == 1) ? palette_copy[k - 1] : COLOR_W'($urandom);
        end
        default:       word = COLOR_W'($urandom);
      endcase
      write_reg(CFG_INDEX_W'(k), word);
    end
    // writes past the register list must leave the palette alone
    write_reg(CFG_INDEX_W'($urandom_range(255, REG_COUNT)), COLOR_W'($urandom));
    write_reg(REG_LAST, COLOR_W'($urandom));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic chan_t corner_value();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic random_pixel(output chan_t r, output chan_t g, output chan_t b);
    case ($urandom_range(7))
      0: begin
        r = chan_t'($urandom);
        g = r;
        b = r;
      end
      1: begin
        r = corner_value();
        g = corner_value();
        b = corner_value();
      end
      2: begin
        r = chan_t'($urandom_range(3));
        g = chan_t'($urandom_range(3));
        b = chan_t'($urandom_range(3));
      end
      default: begin
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
      end
    endcase
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, expected_index_q.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    chan_t r;
    chan_t g;
    chan_t b;
    for (int k = 0; k < REG_COUNT; k++) palette_copy[k] = RESET_PALETTE[k];
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset palette, extremes, grays and ties
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      send_pixel(DIRECTED[n].red, DIRECTED[n].green, DIRECTED[n].blue,
                 DIRECTED[n].typed, DIRECTED[n].index);
    end
    drain(DRAIN_CYCLES);

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_palette(palette_kind_e'(p));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain(0);
        random_pixel(r, g, b);
        send_pixel(r, g, b, 1'b0, '0);
      end
      drain(DRAIN_CYCLES);
    end

    if (expected_index_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d color indexes expected, actual none", $time,
               expected_index_q.size());
    end
    $display("checked %0d color indexes for %0d pixels: grays, corners, small and random",
             results_checked, pixels_sent);
    $display("palettes: reset, all black, all white, duplicated, random; idle on either side");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
